[hw/rtl/arht_pkg.sv]
// ============================================================================
// arht_pkg
// Shared types and constants for the address remap hash table.
// ============================================================================
package arht_pkg;

    localparam int unsigned PageShift = 12;
    localparam logic [31:0] HashMult  = 32'd2654435761;

    // bucket count is a power of two so the bucket is the low product bits
    localparam int unsigned Buckets   = 128;
    localparam int unsigned BktBits   = $clog2(Buckets);

    typedef enum logic [2:0] {
        K_ADD    = 3'd0,
        K_LOOKUP = 3'd1,
        K_REMOVE = 3'd2,
        K_EXISTS = 3'd3,
        K_RSTAT  = 3'd4,
        K_CLEAR  = 3'd5,
        K_RSVD6  = 3'd6,
        K_RSVD7  = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_DISABLED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EXEC,
        BK_CLR
    } t_bk_state;

endpackage

[hw/rtl/arht_front.sv]
// ============================================================================
// arht_front
// Accepts commands, registers the bucket hash in a staging register and queues the
// classified request for the back end.
// ============================================================================
module arht_front #(
    parameter int unsigned ADDR_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [2:0]                  i_kind,
    input  logic [ADDR_BITS-1:0]        i_key,
    input  logic [ADDR_BITS-1:0]        i_new,
    input  logic                        i_pop,
    output logic                        o_full,
    output logic                        o_qv,
    output logic [2:0]                  o_kind,
    output logic [ADDR_BITS-1:0]        o_key,
    output logic [ADDR_BITS-1:0]        o_new,
    output logic [arht_pkg::BktBits-1:0] o_bkt
);
    // page number times constant; only the low bucket bits matter, and they
    // depend only on the low bucket bits of each operand
    localparam int unsigned BKT_BITS = arht_pkg::BktBits;

    logic                 r_sv;
    logic [2:0]           r_skind;
    logic [ADDR_BITS-1:0] r_skey;
    logic [ADDR_BITS-1:0] r_snew;
    logic [BKT_BITS-1:0]  r_prod;
    logic                 r_qv;
    logic [2:0]           r_qkind;
    logic [ADDR_BITS-1:0] r_qkey;
    logic [ADDR_BITS-1:0] r_qnew;
    logic [BKT_BITS-1:0]  r_qbkt;
    logic [BKT_BITS-1:0]  n_prod;
    logic                 advance;

    // multiply the low page bits by the hash constant
    assign n_prod = BKT_BITS'(i_key[arht_pkg::PageShift +: BKT_BITS]
                              * arht_pkg::HashMult[BKT_BITS-1:0]);

    assign o_full  = r_sv || r_qv;
    assign advance = r_sv && (!r_qv || i_pop);

    // stage and queue entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_qv <= 1'b0;
        end else begin
            r_sv <= i_take || (r_sv && !advance);
            r_qv <= advance || (r_qv && !i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_skind <= i_kind;
            r_skey  <= i_key;
            r_snew  <= i_new;
            r_prod  <= n_prod;
        end
        if (advance) begin
            r_qkind <= r_skind;
            r_qkey  <= r_skey;
            r_qnew  <= r_snew;
            r_qbkt  <= r_prod;
        end
    end

    assign o_qv   = r_qv;
    assign o_kind = r_qkind;
    assign o_key  = r_qkey;
    assign o_new  = r_qnew;
    assign o_bkt  = r_qbkt;
endmodule

[hw/rtl/arht_back.sv]
// ============================================================================
// arht_back
// Reads the bucket's ways, resolves the command and writes the bucket back.
// ============================================================================
module arht_back #(
    parameter int unsigned ADDR_BITS = 64,
    parameter int unsigned WAYS      = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_enable,
    input  logic                         i_qv,
    input  logic [2:0]                   i_kind,
    input  logic [ADDR_BITS-1:0]         i_key,
    input  logic [ADDR_BITS-1:0]         i_new,
    input  logic [arht_pkg::BktBits-1:0] i_bkt,
    output logic                         o_pop,
    output logic                         o_done,
    output logic [1:0]                   o_status,
    output logic [ADDR_BITS-1:0]         o_result_addr,
    output logic                         o_found,
    output logic [9:0]                   o_entry_count,
    output logic [31:0]                  o_lookup_count,
    output logic [31:0]                  o_hit_count,
    output logic [31:0]                  o_miss_count
);
    localparam int unsigned WB       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned BUCKETS  = arht_pkg::Buckets;
    localparam int unsigned BKT_BITS = arht_pkg::BktBits;

    // key/value/valid store, one row of WAYS entries per bucket
    logic [WAYS-1:0][ADDR_BITS-1:0] r_kmem [BUCKETS];
    logic [WAYS-1:0][ADDR_BITS-1:0] r_vmem [BUCKETS];
    logic [WAYS-1:0]                r_valid [BUCKETS];

    arht_pkg::t_bk_state r_state, n_state;
    logic [2:0]           r_kind;
    logic [ADDR_BITS-1:0] r_key, r_new;
    logic [BKT_BITS-1:0]  r_bkt;
    logic [BKT_BITS-1:0]  r_clr;
    logic [WAYS-1:0][ADDR_BITS-1:0] r_rk, r_rv;
    logic [WAYS-1:0]      r_rvld;
    logic [9:0]           r_total, n_total;
    logic [31:0]          r_lk, r_ht, r_ms;
    logic [31:0]          n_lk, n_ht, n_ms;
    logic                 r_done;
    logic [1:0]           r_status;
    arht_pkg::t_status    n_status;
    logic [ADDR_BITS-1:0] r_res, n_res;
    logic                 r_found, n_found;
    logic [WAYS-1:0]      n_vrow;
    logic                 vrow_we;
    logic                 do_clear;

    logic [WAYS-1:0] hitv;
    logic            hit, free_any;
    logic [WB-1:0]   hit_w, free_w;
    logic            do_exec;

    assign do_exec = (r_state == arht_pkg::BK_EXEC);

    // match and free-way search over the fetched row
    always_comb begin
        hit = 1'b0; hit_w = '0; free_any = 1'b0; free_w = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            hitv[w] = r_rvld[w] && (r_rk[w] == r_key);
            if (hitv[w]) begin
                hit = 1'b1; hit_w = WB'(w);
            end
            if (!r_rvld[w]) begin
                free_any = 1'b1; free_w = WB'(w);
            end
        end
    end

    // resolve the command against the fetched row
    always_comb begin
        n_status = arht_pkg::ST_OK;
        n_res    = r_key;
        n_found  = 1'b0;
        n_total  = r_total;
        n_lk     = r_lk;
        n_ht     = r_ht;
        n_ms     = r_ms;
        n_vrow   = r_rvld;
        vrow_we  = 1'b0;
        do_clear = 1'b0;
        case (arht_pkg::t_kind'(r_kind))
            arht_pkg::K_RSTAT: begin
                n_lk = '0; n_ht = '0; n_ms = '0;
            end
            arht_pkg::K_RSVD6, arht_pkg::K_RSVD7: begin
            end
            default: begin
                if (!i_enable) begin
                    n_status = arht_pkg::ST_DISABLED;
                end else if (arht_pkg::t_kind'(r_kind) == arht_pkg::K_CLEAR) begin
                    n_total  = '0;
                    do_clear = 1'b1;
                end else begin
                    n_found = hit;
                    if (hit) n_res = r_rv[hit_w];
                    case (arht_pkg::t_kind'(r_kind))
                        arht_pkg::K_ADD: begin
                            if (hit || free_any) n_res = r_new;
                            else n_status = arht_pkg::ST_FULL;
                            if (!hit && free_any) begin
                                n_total        = r_total + 10'd1;
                                n_vrow[free_w] = 1'b1;
                                vrow_we        = 1'b1;
                            end
                        end
                        arht_pkg::K_LOOKUP: begin
                            if (r_lk != '1) n_lk = r_lk + 32'd1;
                            if (hit) begin
                                if (r_ht != '1) n_ht = r_ht + 32'd1;
                            end else begin
                                if (r_ms != '1) n_ms = r_ms + 32'd1;
                                n_status = arht_pkg::ST_NOTFOUND;
                            end
                        end
                        arht_pkg::K_REMOVE: begin
                            if (hit) begin
                                n_total       = r_total - 10'd1;
                                n_vrow[hit_w] = 1'b0;
                                vrow_we       = 1'b1;
                            end else begin
                                n_status = arht_pkg::ST_NOTFOUND;
                            end
                        end
                        default: begin
                            if (!hit) n_status = arht_pkg::ST_NOTFOUND;
                        end
                    endcase
                end
            end
        endcase
    end

    // next state
    always_comb begin
        case (r_state)
            arht_pkg::BK_IDLE: n_state = i_qv ? arht_pkg::BK_READ : arht_pkg::BK_IDLE;
            arht_pkg::BK_READ: n_state = arht_pkg::BK_EXEC;
            arht_pkg::BK_EXEC: n_state = do_clear ? arht_pkg::BK_CLR : arht_pkg::BK_IDLE;
            arht_pkg::BK_CLR:  n_state = (r_clr == BKT_BITS'(BUCKETS - 1))
                                         ? arht_pkg::BK_IDLE : arht_pkg::BK_CLR;
            default:           n_state = arht_pkg::BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_pop = (r_state == arht_pkg::BK_IDLE) && i_qv;
    end

    // start in the clearing pass so every valid row is wiped after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= arht_pkg::BK_CLR;
        else          r_state <= n_state;
    end

    // advance the clearing row, wrapping back to zero at the end of a pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                          r_clr <= '0;
        else if (r_state == arht_pkg::BK_CLR) r_clr <= r_clr + BKT_BITS'(1);
    end

    // capture the request, then read the row
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= i_kind;
            r_key  <= i_key;
            r_new  <= i_new;
            r_bkt  <= i_bkt;
        end
        if (r_state == arht_pkg::BK_READ) begin
            r_rk   <= r_kmem[r_bkt];
            r_rv   <= r_vmem[r_bkt];
            r_rvld <= r_valid[r_bkt];
        end
    end

    // valid rows: one row per cycle in the clearing pass, else write back
    always_ff @(posedge i_clk) begin
        if (r_state == arht_pkg::BK_CLR) begin
            r_valid[r_clr] <= '0;
        end else if (do_exec && vrow_we) begin
            r_valid[r_bkt] <= n_vrow;
        end
    end

    // write back key and value for an add
    always_ff @(posedge i_clk) begin
        if (do_exec && i_enable && arht_pkg::t_kind'(r_kind) == arht_pkg::K_ADD) begin
            if (hit) begin
                r_vmem[r_bkt][hit_w] <= r_new;
            end else if (free_any) begin
                r_kmem[r_bkt][free_w] <= r_key;
                r_vmem[r_bkt][free_w] <= r_new;
            end
        end
    end

    // register counters and the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0; r_total <= '0;
            r_lk <= '0; r_ht <= '0; r_ms <= '0;
        end else begin
            r_done <= do_exec;
            if (do_exec) begin
                r_status <= n_status;
                r_res    <= n_res;
                r_found  <= n_found;
                r_total  <= n_total;
                r_lk     <= n_lk;
                r_ht     <= n_ht;
                r_ms     <= n_ms;
            end
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_result_addr  = r_res;
    assign o_found        = r_found;
    assign o_entry_count  = r_total;
    assign o_lookup_count = r_lk;
    assign o_hit_count    = r_ht;
    assign o_miss_count   = r_ms;
endmodule

[hw/rtl/address_remap_hash_table.sv]
// ============================================================================
// address_remap_hash_table
// Hashed key to address translation table with fixed-way buckets.
// ============================================================================
// channel  | handshake               | payload
// command  | i_start / o_busy        | i_kind, i_key_addr, i_new_addr
// result   | o_done (one cycle)      | o_status .. o_miss_count
// config   | i_cfg_we                | i_cfg_wdata (table_enable)
// A command passes the hash front end's stage and queue registers, then the
// back end's request capture, bucket read, resolve/write-back and result
// register. The back end handles one command at a time through its single row port;
// one command can wait in the front end meanwhile, and o_busy is high then.
// Reset and clear-all run a pass over all 128 buckets that wipes one valid row per
// cycle; queued commands wait behind it. Results cannot stall.
module address_remap_hash_table #(
    parameter int unsigned WAYS      = 4,
    parameter int unsigned ADDR_BITS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [2:0]           i_kind,
    input  logic [ADDR_BITS-1:0] i_key_addr,
    input  logic [ADDR_BITS-1:0] i_new_addr,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output logic [ADDR_BITS-1:0] o_result_addr,
    output logic                 o_found,
    output logic [9:0]           o_entry_count,
    output logic [31:0]          o_lookup_count,
    output logic [31:0]          o_hit_count,
    output logic [31:0]          o_miss_count
);
    logic                         r_enable;
    logic                         full, qv, pop;
    logic [2:0]                   q_kind;
    logic [ADDR_BITS-1:0]         q_key, q_new;
    logic [arht_pkg::BktBits-1:0] q_bkt;

    // hold the enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_enable <= 1'b1;
        else if (i_cfg_we) r_enable <= i_cfg_wdata;
    end

    assign o_busy = full;

    arht_front #(.ADDR_BITS(ADDR_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_take (i_start && !full),
        .i_kind, .i_key(i_key_addr), .i_new(i_new_addr),
        .i_pop  (pop),
        .o_full (full), .o_qv(qv), .o_kind(q_kind), .o_key(q_key), .o_new(q_new),
        .o_bkt  (q_bkt)
    );

    arht_back #(.ADDR_BITS(ADDR_BITS), .WAYS(WAYS)) u_back (
        .i_clk, .i_rst_n,
        .i_enable (r_enable),
        .i_qv     (qv), .i_kind(q_kind), .i_key(q_key), .i_new(q_new), .i_bkt(q_bkt),
        .o_pop    (pop),
        .o_done, .o_status, .o_result_addr, .o_found, .o_entry_count,
        .o_lookup_count, .o_hit_count, .o_miss_count
    );
endmodule

[hw/rtl/arht_checker.sv]
// ============================================================================
// arht_checker
// Port-level checks on the address remap hash table.
// ============================================================================
module arht_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic        o_found,
    input logic [31:0] o_lookup_count,
    input logic [31:0] o_hit_count,
    input logic [31:0] o_miss_count
);
    // a found key never reports not-found, full or disabled
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> o_status == arht_pkg::ST_OK)
        else $error("found with error status");

    // results never come back to back
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back to back results");

    // the lookup count moves only when a result is shown
    a_cnt_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_done && $past(i_rst_n)) |-> $stable(o_lookup_count))
        else $error("lookup count moved without result");

    // hits never exceed lookups
    a_hit_le: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_count <= o_lookup_count)
        else $error("hits above lookups");

    logic unused;
    assign unused = i_start ^ o_busy ^ (|o_miss_count);
endmodule

bind address_remap_hash_table arht_checker u_arht_checker (
    .i_clk, .i_rst_n, .i_start, .o_busy, .o_done, .o_status, .o_found,
    .o_lookup_count, .o_hit_count, .o_miss_count
);

[test/address_remap_hash_table_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_remap_hash_table_checker
// Watches the command, config and result channels of the remap table. Keeps
// its own copy of the buckets, counters and enable bit, predicts every
// result and compares each field against the oldest prediction.
// ----------------------------------------------------------------------------
module address_remap_hash_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [2:0]  i_kind,
    input  logic [63:0] i_key_addr,
    input  logic [63:0] i_new_addr,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_done,
    input  logic [1:0]  i_status,
    input  logic [63:0] i_result_addr,
    input  logic        i_found,
    input  logic [9:0]  i_entry_count,
    input  logic [31:0] i_lookup_count,
    input  logic [31:0] i_hit_count,
    input  logic [31:0] i_miss_count,
    output int          o_pending,
    output int          o_fail_count
);

    localparam int NumBuckets = 128;
    localparam int NumWays    = 4;
    localparam int NumSlots   = NumBuckets * NumWays;

    typedef struct packed {
        arht_pkg::t_status status;
        logic [63:0]       addr;
        logic              found;
        logic [9:0]        entries;
        logic [31:0]       lookups;
        logic [31:0]       hits;
        logic [31:0]       misses;
    } t_remap_result;

    // mirror of the table
    logic        slot_valid [NumSlots];
    logic [63:0] slot_key   [NumSlots];
    logic [63:0] slot_value [NumSlots];
    logic [9:0]  mapped_total;
    logic [31:0] lookups_cnt, hits_cnt, misses_cnt;
    logic        table_on;

    t_remap_result remap_q[$];

    function automatic logic [31:0] sat_bump(logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    // Apply one command to the mirror and return the expected response
    function automatic t_remap_result remap_predict(arht_pkg::t_kind kind,
                                                    logic [63:0] key,
                                                    logic [63:0] new_addr);
        t_remap_result r;
        logic [63:0]   prod;
        int            base;
        int            hit_slot;
        int            free_slot;
        prod      = (key >> 12) * 64'd2654435761;
        base      = int'(prod[6:0]) * NumWays;
        hit_slot  = -1;
        free_slot = -1;
        r.status  = arht_pkg::ST_OK;
        r.addr    = key;
        r.found   = 1'b0;
        for (int w = NumWays - 1; w >= 0; w--) begin
            if (slot_valid[base + w] && slot_key[base + w] == key) hit_slot = base + w;
            if (!slot_valid[base + w]) free_slot = base + w;
        end
        if (kind == arht_pkg::K_RSTAT) begin
            lookups_cnt = '0;
            hits_cnt    = '0;
            misses_cnt  = '0;
        end else if (kind == arht_pkg::K_RSVD6 || kind == arht_pkg::K_RSVD7) begin
            // no effect
        end else if (!table_on) begin
            r.status = arht_pkg::ST_DISABLED;
        end else if (kind == arht_pkg::K_CLEAR) begin
            for (int i = 0; i < NumSlots; i++) slot_valid[i] = 1'b0;
            mapped_total = '0;
        end else begin
            if (hit_slot >= 0) begin
                r.found = 1'b1;
                r.addr  = slot_value[hit_slot];
            end
            case (kind)
                arht_pkg::K_ADD: begin
                    if (hit_slot < 0 && free_slot >= 0) begin
                        hit_slot             = free_slot;
                        slot_valid[hit_slot] = 1'b1;
                        slot_key[hit_slot]   = key;
                        mapped_total         = mapped_total + 10'd1;
                    end
                    if (hit_slot >= 0) begin
                        slot_value[hit_slot] = new_addr;
                        r.addr               = new_addr;
                    end else begin
                        r.status = arht_pkg::ST_FULL;
                    end
                end
                arht_pkg::K_LOOKUP: begin
                    lookups_cnt = sat_bump(lookups_cnt);
                    if (r.found) begin
                        hits_cnt = sat_bump(hits_cnt);
                    end else begin
                        misses_cnt = sat_bump(misses_cnt);
                        r.status   = arht_pkg::ST_NOTFOUND;
                    end
                end
                arht_pkg::K_REMOVE: begin
                    if (r.found) begin
                        slot_valid[hit_slot] = 1'b0;
                        mapped_total         = mapped_total - 10'd1;
                    end else begin
                        r.status = arht_pkg::ST_NOTFOUND;
                    end
                end
                default: begin
                    if (!r.found) r.status = arht_pkg::ST_NOTFOUND;
                end
            endcase
        end
        r.entries = mapped_total;
        r.lookups = lookups_cnt;
        r.hits    = hits_cnt;
        r.misses  = misses_cnt;
        return r;
    endfunction

    // Compare results, then record new transfers and config writes
    always @(posedge i_clk) begin
        t_remap_result exp_r;
        if (!i_rst_n) begin
            for (int i = 0; i < NumSlots; i++) slot_valid[i] = 1'b0;
            mapped_total = '0;
            lookups_cnt  = '0;
            hits_cnt     = '0;
            misses_cnt   = '0;
            table_on     = 1'b1;
            remap_q.delete();
        end else begin
            if (i_done) begin
                if (remap_q.size() == 0) begin
                    $error("result with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = remap_q.pop_front();
                    if (i_status !== exp_r.status ||
                        i_result_addr !== exp_r.addr ||
                        i_found !== exp_r.found ||
                        i_entry_count !== exp_r.entries ||
                        i_lookup_count !== exp_r.lookups ||
                        i_hit_count !== exp_r.hits ||
                        i_miss_count !== exp_r.misses) begin
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (i_status !== exp_r.status)
                        $error("status: expected %0d got %0d", exp_r.status, i_status);
                    if (i_result_addr !== exp_r.addr)
                        $error("result_addr: expected %h got %h", exp_r.addr, i_result_addr);
                    if (i_found !== exp_r.found)
                        $error("found: expected %0d got %0d", exp_r.found, i_found);
                    if (i_entry_count !== exp_r.entries)
                        $error("entry_count: expected %0d got %0d", exp_r.entries,
                               i_entry_count);
                    if (i_lookup_count !== exp_r.lookups)
                        $error("lookup_count: expected %0d got %0d", exp_r.lookups,
                               i_lookup_count);
                    if (i_hit_count !== exp_r.hits)
                        $error("hit_count: expected %0d got %0d", exp_r.hits, i_hit_count);
                    if (i_miss_count !== exp_r.misses)
                        $error("miss_count: expected %0d got %0d", exp_r.misses,
                               i_miss_count);
                end
            end
            if (i_start && !i_busy)
                remap_q.push_back(remap_predict(arht_pkg::t_kind'(i_kind), i_key_addr,
                                                i_new_addr));
            if (i_cfg_we) table_on = i_cfg_wdata;
        end
        o_pending <= remap_q.size();
    end

    initial o_fail_count = 0;

endmodule

[test/address_remap_hash_table_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_remap_hash_table_test
// Drives the remap table with directed commands (full buckets, updates,
// removes, disabled table, stats reset, clear) and then random phases over a
// small colliding key pool, toggling the enable between phases. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module address_remap_hash_table_test;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [2:0]  i_kind = 3'd0;
    logic [63:0] i_key_addr = '0;
    logic [63:0] i_new_addr = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        o_busy, o_done, o_found;
    logic [1:0]  o_status;
    logic [63:0] o_result_addr;
    logic [9:0]  o_entry_count;
    logic [31:0] o_lookup_count, o_hit_count, o_miss_count;
    int          pending, fail_count;
    logic [63:0] key_pool [48];
    bit          no_gaps;

    address_remap_hash_table u_dut (.*);

    address_remap_hash_table_checker u_chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_kind, .i_key_addr, .i_new_addr,
        .i_cfg_we, .i_cfg_wdata, .i_done(o_done), .i_status(o_status),
        .i_result_addr(o_result_addr), .i_found(o_found), .i_entry_count(o_entry_count),
        .i_lookup_count(o_lookup_count), .i_hit_count(o_hit_count),
        .i_miss_count(o_miss_count), .o_pending(pending), .o_fail_count(fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one command and hold it until the block takes the transfer
    task automatic issue(arht_pkg::t_kind kind, logic [63:0] key, logic [63:0] new_addr,
                         int gap);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start    <= 1'b1;
        i_kind     <= kind;
        i_key_addr <= key;
        i_new_addr <= new_addr;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Drain outstanding results, then write the enable bit
    task automatic set_enable(logic en);
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        arht_pkg::t_kind kind;
        logic [63:0]     key;
        int              r;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 35)      kind = arht_pkg::K_ADD;
            else if (r < 65) kind = arht_pkg::K_LOOKUP;
            else if (r < 78) kind = arht_pkg::K_REMOVE;
            else if (r < 91) kind = arht_pkg::K_EXISTS;
            else if (r < 94) kind = arht_pkg::K_RSTAT;
            else if (r < 96) kind = arht_pkg::K_CLEAR;
            else             kind = arht_pkg::t_kind'($urandom_range(6, 7));
            if ($urandom_range(0, 4) == 0) key = {$urandom, $urandom};
            else key = key_pool[$urandom_range(0, 47)];
            issue(kind, key, {$urandom, $urandom}, pick_gap());
        end
    endtask

    // Stimulus
    initial begin
        // pool keys share a few pages so buckets fill up
        for (int i = 0; i < 48; i++) begin
            if (i < 36) key_pool[i] = {52'(i % 3), 12'($urandom)};
            else key_pool[i] = {$urandom, $urandom};
        end
        no_gaps = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_enable(1'b1);

        // fill bucket 0, overflow it, update, then walk the other kinds
        issue(arht_pkg::K_ADD, 64'h0000, 64'h0, 0);
        issue(arht_pkg::K_ADD, 64'h0001, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        issue(arht_pkg::K_ADD, 64'h0002, 64'h8000_0000_0000_0001, 2);
        issue(arht_pkg::K_ADD, 64'h0FFF, 64'h1234_5678_9ABC_DEF0, 0);
        issue(arht_pkg::K_ADD, 64'h0ABC, 64'h5555_5555_5555_5555, 0);
        issue(arht_pkg::K_ADD, 64'h0001, 64'hAAAA_AAAA_AAAA_AAAA, 1);
        issue(arht_pkg::K_LOOKUP, 64'h0001, 64'h0, 0);
        issue(arht_pkg::K_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 0);
        issue(arht_pkg::K_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        issue(arht_pkg::K_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 3);
        issue(arht_pkg::K_EXISTS, 64'h0002, 64'h0, 0);
        issue(arht_pkg::K_EXISTS, 64'h0003, 64'h0, 0);
        issue(arht_pkg::K_REMOVE, 64'h0002, 64'h0, 0);
        issue(arht_pkg::K_REMOVE, 64'h0002, 64'h0, 0);
        issue(arht_pkg::K_ADD, 64'h0ABC, 64'h5555_5555_5555_5555, 0);
        issue(arht_pkg::K_RSVD6, 64'h0001, 64'h1, 0);
        issue(arht_pkg::K_RSVD7, 64'h0001, 64'h1, 0);
        issue(arht_pkg::K_RSTAT, 64'h0001, 64'h0, 0);
        issue(arht_pkg::K_CLEAR, 64'h0000, 64'h0, 0);
        issue(arht_pkg::K_LOOKUP, 64'h0000, 64'h0, 0);

        // disabled table
        set_enable(1'b0);
        issue(arht_pkg::K_ADD, 64'h0005, 64'h77, 0);
        issue(arht_pkg::K_LOOKUP, 64'h0005, 64'h0, 0);
        issue(arht_pkg::K_REMOVE, 64'h0005, 64'h0, 0);
        issue(arht_pkg::K_EXISTS, 64'h0005, 64'h0, 0);
        issue(arht_pkg::K_CLEAR, 64'h0005, 64'h0, 0);
        issue(arht_pkg::K_RSTAT, 64'h0005, 64'h0, 0);
        issue(arht_pkg::K_RSVD7, 64'h0005, 64'h0, 0);

        set_enable(1'b1);
        random_phase(450);
        set_enable(1'b1);
        random_phase(450);
        set_enable(1'b0);
        random_phase(80);
        set_enable(1'b1);
        random_phase(450);
        set_enable(1'b0);
        set_enable(1'b1);
        random_phase(450);

        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Run limit
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
